### src/bgcos_pkg.sv
// ----------------------------------------------------------------------------
// bgcos_pkg
// Shared constants and types of the bitmap Gray-code order sorter.
// ----------------------------------------------------------------------------
package bgcos_pkg;

    localparam int MAX_BITMAPS_DEF      = 64;
    localparam int WORDS_PER_BITMAP_DEF = 4;
    localparam int WORD_BITS_DEF        = 32;

    localparam int IN_WORD_W   = 32;
    localparam int LEN_W       = 8;
    localparam int SRC_IDX_W   = 6;

    localparam logic ORDER_LEX  = 1'b0;
    localparam logic ORDER_GRAY = 1'b1;

    // Result of one word step of the compare unit.
    typedef struct packed {
        logic differ;
        logic ahead;
        logic par;
    } cmp_res_t;

endpackage

### src/bitmap_gray_code_order_sorter.sv
// ----------------------------------------------------------------------------
// bitmap_gray_code_order_sorter
// Loads a set of bitmaps and emits their load indices in sorted order.
// ----------------------------------------------------------------------------
// Words load at one per cycle while the block is in its load phase. The word
// that ends the set starts an insertion sort run by one sequencer around a
// single word compare unit: each comparison steps through the word slots until
// the lengths or a word differ or the last slot is reached, and each insertion
// step first reads the order table, so n bitmaps take on the order of n*n/2
// comparisons in the worst case. Results then leave one at a time; the next is
// not read until the sink has taken the current one. The input is not ready
// from the end of a set until its last result has been taken.
module bitmap_gray_code_order_sorter import bgcos_pkg::*; #(
    parameter int MAX_BITMAPS      = MAX_BITMAPS_DEF,
    parameter int WORDS_PER_BITMAP = WORDS_PER_BITMAP_DEF,
    parameter int WORD_BITS        = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_sort_order,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_WORD_W-1:0] s_word,
    input  logic [LEN_W-1:0]     s_bit_count,
    input  logic                 s_end_of_bitmap,
    input  logic                 s_end_of_set,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SRC_IDX_W-1:0] m_source_index,
    output logic [LEN_W-1:0]     m_sorted_bit_count,
    output logic                 m_last,
    output logic                 m_overflow
);

    localparam int IDXW  = $clog2(MAX_BITMAPS);
    localparam int CNTW  = $clog2(MAX_BITMAPS + 1);
    localparam int PW    = $clog2(WORDS_PER_BITMAP + 1);
    localparam int WSW   = (WORDS_PER_BITMAP > 1) ? $clog2(WORDS_PER_BITMAP) : 1;
    localparam int WDEP  = MAX_BITMAPS * WORDS_PER_BITMAP;
    localparam int WAW   = $clog2(WDEP);
    localparam int METAW = PW + LEN_W;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_ORD_RD   = 4'd1;
    localparam logic [3:0] S_ORD_WAIT = 4'd2;
    localparam logic [3:0] S_CMP      = 4'd3;
    localparam logic [3:0] S_OUT_RD   = 4'd4;
    localparam logic [3:0] S_OUT_IDX  = 4'd5;
    localparam logic [3:0] S_OUT_LEN  = 4'd6;
    localparam logic [3:0] S_OUT_WAIT = 4'd7;

    function automatic logic [WAW-1:0] word_addr(input logic [IDXW-1:0] idx,
                                                 input logic [WSW-1:0] w);
        word_addr = WAW'(idx) * WAW'(WORDS_PER_BITMAP) + WAW'(w);
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic                 drop_reg, drop_next;
    logic [CNTW-1:0]      n_reg, n_next;
    logic [IDXW-1:0]      cur_reg, cur_next;
    logic [IDXW-1:0]      j_reg, j_next;
    logic [IDXW-1:0]      p_reg, p_next;
    logic [WSW-1:0]       w_reg, w_next;
    logic                 par_reg, par_next;
    logic [IDXW-1:0]      k_reg, k_next;
    logic [IDXW-1:0]      idx_reg, idx_next;
    logic                 sort_order_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [SRC_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic [LEN_W-1:0]     m_len_reg, m_len_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_ovf_reg, m_ovf_next;

    logic [WORD_BITS-1:0] word_in;
    logic                 w_we;
    logic [WAW-1:0]       w_waddr, w_raddr_a, w_raddr_b;
    logic [WORD_BITS-1:0] w_rdata_a, w_rdata_b;
    logic                 m_we;
    logic [IDXW-1:0]      m_raddr_a, m_raddr_b;
    logic [METAW-1:0]     meta_wdata, meta_rdata_a, meta_rdata_b;
    logic                 o_we;
    logic [IDXW-1:0]      o_waddr, o_raddr_a, o_raddr_b;
    logic [IDXW-1:0]      o_wdata, o_rdata_a, o_rdata_b;

    logic [WSW-1:0]       w_adv;
    logic [PW-1:0]        fill_a, fill_b;
    logic [LEN_W-1:0]     len_a, len_b;
    logic [WORD_BITS-1:0] x_word, y_word;
    cmp_res_t             cmp_res;
    logic                 accept;
    logic [CNTW-1:0]      next_i;
    logic [CNTW-1:0]      k_plus;

    generate
        if (WORD_BITS >= IN_WORD_W) begin : g_wide
            assign word_in = WORD_BITS'(s_word);
        end else begin : g_narrow
            assign word_in = s_word[WORD_BITS-1:0];
        end
    endgenerate

    bgcos_ram #(.WIDTH(WORD_BITS), .DEPTH(WDEP)) u_word_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(word_in),
        .raddr_a(w_raddr_a), .rdata_a(w_rdata_a),
        .raddr_b(w_raddr_b), .rdata_b(w_rdata_b)
    );

    // Each entry holds the number of words loaded and the bit length.
    bgcos_ram #(.WIDTH(METAW), .DEPTH(MAX_BITMAPS)) u_meta_ram (
        .aclk(aclk), .we(m_we), .waddr(IDXW'(cnt_reg)), .wdata(meta_wdata),
        .raddr_a(m_raddr_a), .rdata_a(meta_rdata_a),
        .raddr_b(m_raddr_b), .rdata_b(meta_rdata_b)
    );

    bgcos_ram #(.WIDTH(IDXW), .DEPTH(MAX_BITMAPS)) u_order_ram (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr_a(o_raddr_a), .rdata_a(o_rdata_a),
        .raddr_b(o_raddr_b), .rdata_b(o_rdata_b)
    );

    assign fill_a = meta_rdata_a[METAW-1:LEN_W];
    assign fill_b = meta_rdata_b[METAW-1:LEN_W];
    assign len_a  = meta_rdata_a[LEN_W-1:0];
    assign len_b  = meta_rdata_b[LEN_W-1:0];

    // Word slots beyond those loaded read as zero.
    assign x_word = (PW'(w_reg) < fill_a) ? w_rdata_a : '0;
    assign y_word = (PW'(w_reg) < fill_b) ? w_rdata_b : '0;

    bgcos_cmp #(.WORD_BITS(WORD_BITS)) u_cmp (
        .x(x_word), .y(y_word), .par_in(par_reg), .mode(sort_order_reg),
        .res(cmp_res)
    );

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == S_LOAD);
    assign cfg_ready  = 1'b1;
    assign w_adv      = (w_reg == WSW'(WORDS_PER_BITMAP - 1)) ? w_reg : w_reg + WSW'(1);
    assign next_i     = CNTW'(cur_reg) + CNTW'(1);
    assign k_plus     = CNTW'(k_reg) + CNTW'(1);
    assign meta_wdata = {pos_reg + PW'(1), s_bit_count};
    assign w_waddr    = word_addr(IDXW'(cnt_reg), WSW'(pos_reg));
    assign o_waddr    = j_reg;
    assign o_raddr_a  = j_reg - IDXW'(1);
    assign o_raddr_b  = k_reg;

    always_comb begin
        w_raddr_a = word_addr(cur_reg, w_adv);
        w_raddr_b = word_addr(p_reg, w_adv);
        m_raddr_a = cur_reg;
        m_raddr_b = p_reg;
        if (state_reg == S_ORD_WAIT) begin
            w_raddr_a = word_addr(cur_reg, '0);
            w_raddr_b = word_addr(o_rdata_a, '0);
            m_raddr_b = o_rdata_a;
        end else if (state_reg == S_OUT_IDX) begin
            m_raddr_a = o_rdata_b;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        drop_next    = drop_reg;
        n_next       = n_reg;
        cur_next     = cur_reg;
        j_next       = j_reg;
        p_next       = p_reg;
        w_next       = w_reg;
        par_next     = par_reg;
        k_next       = k_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_len_next   = m_len_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        w_we         = 1'b0;
        m_we         = 1'b0;
        o_we         = 1'b0;
        o_wdata      = cur_reg;

        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    if (cnt_reg < CNTW'(MAX_BITMAPS)) begin
                        if (pos_reg < PW'(WORDS_PER_BITMAP)) begin
                            w_we     = 1'b1;
                            m_we     = 1'b1;
                            pos_next = pos_reg + PW'(1);
                        end else begin
                            drop_next = 1'b1;
                        end
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_end_of_bitmap || s_end_of_set) begin
                        if (cnt_reg < CNTW'(MAX_BITMAPS)) begin
                            cnt_next = cnt_reg + CNTW'(1);
                        end
                        pos_next = '0;
                    end
                    if (s_end_of_set) begin
                        n_next     = (cnt_reg < CNTW'(MAX_BITMAPS)) ?
                                     cnt_reg + CNTW'(1) : cnt_reg;
                        cur_next   = '0;
                        j_next     = '0;
                        state_next = S_ORD_RD;
                    end
                end
            end
            S_ORD_RD: begin
                if (j_reg == '0) begin
                    o_we    = 1'b1;
                    o_wdata = cur_reg;
                    if (next_i == n_reg) begin
                        k_next     = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        cur_next = IDXW'(next_i);
                        j_next   = IDXW'(next_i);
                    end
                end else begin
                    state_next = S_ORD_WAIT;
                end
            end
            S_ORD_WAIT: begin
                p_next     = o_rdata_a;
                w_next     = '0;
                par_next   = 1'b0;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (len_a != len_b || cmp_res.differ ||
                    w_reg == WSW'(WORDS_PER_BITMAP - 1)) begin
                    o_we = 1'b1;
                    if ((len_a != len_b) ? (len_a < len_b) :
                        (cmp_res.differ && cmp_res.ahead)) begin
                        // Shift the predecessor up and keep walking down.
                        o_wdata    = p_reg;
                        j_next     = j_reg - IDXW'(1);
                        state_next = S_ORD_RD;
                    end else begin
                        o_wdata = cur_reg;
                        if (next_i == n_reg) begin
                            k_next     = '0;
                            state_next = S_OUT_RD;
                        end else begin
                            cur_next   = IDXW'(next_i);
                            j_next     = IDXW'(next_i);
                            state_next = S_ORD_RD;
                        end
                    end
                end else begin
                    par_next = cmp_res.par;
                    w_next   = w_adv;
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_IDX;
            end
            S_OUT_IDX: begin
                idx_next   = o_rdata_b;
                state_next = S_OUT_LEN;
            end
            S_OUT_LEN: begin
                m_valid_next = 1'b1;
                m_idx_next   = SRC_IDX_W'(idx_reg);
                m_len_next   = len_a;
                m_last_next  = (k_plus == n_reg);
                m_ovf_next   = drop_reg;
                state_next   = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        cnt_next   = '0;
                        pos_next   = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        k_next     = IDXW'(k_plus);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            drop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            sort_order_reg <= ORDER_LEX;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                sort_order_reg <= cfg_sort_order;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        cur_reg    <= cur_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        w_reg      <= w_next;
        par_reg    <= par_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        m_idx_reg  <= m_idx_next;
        m_len_reg  <= m_len_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_source_index     = m_idx_reg;
    assign m_sorted_bit_count = m_len_reg;
    assign m_last             = m_last_reg;
    assign m_overflow         = m_ovf_reg;

endmodule

### src/bgcos_ram.sv
// ----------------------------------------------------------------------------
// bgcos_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bgcos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/bgcos_cmp.sv
// ----------------------------------------------------------------------------
// bgcos_cmp
// One word step of the bitmap compare: finds the lowest differing bit and
// decides the order in lexicographic or reflected Gray-code mode.
// ----------------------------------------------------------------------------
module bgcos_cmp import bgcos_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic                 par_in,
    input  logic                 mode,
    output cmp_res_t             res
);

    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] low;
    logic [WORD_BITS-1:0] upto;

    always_comb begin
        diff = x ^ y;
        low  = diff & (~diff + WORD_BITS'(1));
        upto = (low - WORD_BITS'(1)) | low;
        res.differ = (diff != '0);
        if (mode == ORDER_LEX) begin
            res.ahead = ((x & low) == '0);
        end else begin
            res.ahead = ~(par_in ^ (^(x & upto)));
        end
        res.par = par_in ^ (^x);
    end

endmodule
